### hw/rtl/life_generation_torus_defines.svh
// Assertion macros shared by the Life generation block.
// Used by the top level; no other dependencies.
`ifndef LIFE_GENERATION_TORUS_DEFINES_SVH
`define LIFE_GENERATION_TORUS_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define LGT_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset
`define LGT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lgt_pkg.sv
// Shared types and constants for the Life generation block.
// No dependencies.
package lgt_pkg;

    // Field and register widths
    localparam int ROW_W      = 64;
    localparam int IDX_W      = 6;
    localparam int CFG_DATA_W = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CNT_W      = 8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    // Register reset values
    localparam logic [CFG_DATA_W-1:0] GRID_WIDTH_RST  = 7'd40;
    localparam logic [CFG_DATA_W-1:0] GRID_HEIGHT_RST = 7'd20;

    // Life rule
    localparam logic [3:0] SURVIVE_LO = 4'd2;
    localparam logic [3:0] SURVIVE_HI = 4'd3;
    localparam logic [3:0] BIRTH      = 4'd3;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } lgt_state_t;

    typedef struct packed {
        logic [ROW_W-1:0] cur_row_cells;
    } lgt_in_t;

    typedef struct packed {
        logic [ROW_W-1:0] next_row_cells;
        logic [IDX_W-1:0] out_row_index;
        logic             last_row;
    } lgt_out_t;

endpackage

### hw/rtl/lgt_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
// Payload type is a parameter; no other dependencies.
interface lgt_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/lgt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lgt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

### hw/rtl/lgt_cell.sv
// One column cell: holds a three-row window of its column and applies the Life rule.
// Uses lgt_pkg for the rule constants.
module lgt_cell (
    input  logic       clk,
    input  logic       shift,
    input  logic       bit_in,
    input  logic       active,
    input  logic [1:0] left_sum,
    input  logic [1:0] right_sum,
    output logic [1:0] col_sum,
    output logic       next_bit
);
    logic       up_reg, cur_reg, dn_reg;
    logic [3:0] n;

    // Window shifts down by one row per transaction from the store
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            up_reg  <= cur_reg;
            cur_reg <= dn_reg;
            dn_reg  <= bit_in;
        end
    end

    // Column sum handed to both neighbors
    assign col_sum = 2'(up_reg) + 2'(cur_reg) + 2'(dn_reg);

    // Neighbor count: both side columns plus cells above and below
    assign n = 4'(left_sum) + 4'(right_sum) + 4'(up_reg) + 4'(dn_reg);

    always_comb
    begin
        if (cur_reg)
        begin
            next_bit = active && (n == lgt_pkg::SURVIVE_LO || n == lgt_pkg::SURVIVE_HI);
        end
        else
        begin
            next_bit = active && (n == lgt_pkg::BIRTH);
        end
    end
endmodule

### hw/rtl/lgt_cell_row.sv
// Row of column cells wired as a ring that wraps at the programmed width.
// Instantiates lgt_cell.
module lgt_cell_row #(
    parameter int NC = 64
) (
    input  logic                                 clk,
    input  logic                                 shift,
    input  logic [NC-1:0]                        row_in,
    input  logic [((NC > 1) ? $clog2(NC) : 1)-1:0] wmax,
    output logic [NC-1:0]                        next_row
);
    localparam int CW = (NC > 1) ? $clog2(NC) : 1;

    logic [1:0] col_sum   [NC];
    logic [1:0] left_sum  [NC];
    logic [1:0] right_sum [NC];

    genvar c;
    generate
        for (c = 0; c < NC; c++)
        begin : g_col
            // Left neighbor: cell 0 wraps to the last active column
            if (c == 0)
            begin : g_left_wrap
                assign left_sum[c] = col_sum[wmax];
            end
            else
            begin : g_left
                assign left_sum[c] = col_sum[c-1];
            end

            // Right neighbor: the last active column wraps to cell 0
            if (c == NC - 1)
            begin : g_right_wrap
                assign right_sum[c] = col_sum[0];
            end
            else
            begin : g_right
                assign right_sum[c] = (wmax == CW'(c)) ? col_sum[0] : col_sum[c+1];
            end

            lgt_cell u_cell (
                .clk       (clk),
                .shift     (shift),
                .bit_in    (row_in[c]),
                .active    (CW'(c) <= wmax),
                .left_sum  (left_sum[c]),
                .right_sum (right_sum[c]),
                .col_sum   (col_sum[c]),
                .next_bit  (next_row[c])
            );
        end
    endgenerate
endmodule

### hw/rtl/life_generation_torus.sv
// Top level of the toroidal Life generation block.
// Uses lgt_pkg, lgt_stream_if, lgt_ram, lgt_cell_row and the assertion macro header.
//
// Usage:
//   in_row  : one transaction per row of the current generation, row 0 first.
//   out_row : one transaction per row of the next generation, with its index
//             and last_row set on the final row.
//   cfg_we/cfg_idx/cfg_wdata write grid_width (index 0) or grid_height (index 1).
// Each accepted row is written into the row store. The transaction carrying
// the last row starts emission: the store is read once per cycle while out_row
// is not stalled, in the order last row, 0, 1, ..., last row, 0 (height + 2
// reads), each read shifting the column cell window down by one row. Rows pass
// through the store read register, the cell window and the output register;
// once the window holds rows last, 0 and 1, one output row follows per cycle
// while out_row is not stalled. in_row.ready is low during emission. A stalled
// out_row freezes the read pipeline and the cell window; nothing is dropped.
// Reset clears the load count, the state machine and the output valid, and
// restores width 40 and height 20; store contents are not cleared.
`include "life_generation_torus_defines.svh"

module life_generation_torus #(
    parameter int MAX_COLUMNS = 64,
    parameter int MAX_ROWS    = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [lgt_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [lgt_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    lgt_stream_if.sink                        in_row,
    lgt_stream_if.source                      out_row
);
    localparam int NC     = MAX_COLUMNS;
    localparam int CW     = (NC > 1) ? $clog2(NC) : 1;
    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int H_CAP  = (MAX_ROWS < 127) ? MAX_ROWS : 127;
    localparam int RW     = lgt_pkg::ROW_W;
    localparam int DW     = lgt_pkg::CFG_DATA_W;
    localparam int CTW    = lgt_pkg::CNT_W;
    localparam int XW     = lgt_pkg::IDX_W;

    // Registers
    logic [DW-1:0]       gw_reg, gh_reg;
    lgt_pkg::lgt_state_t st_reg, st_next;
    logic [DW-1:0]       loaded_reg, loaded_next;
    logic [DW-1:0]       h_reg, h_next;
    logic [CTW-1:0]      rd_cnt_reg, rd_cnt_next;
    logic [CTW-1:0]      sh_cnt_reg, sh_cnt_next;
    logic [DW-1:0]       out_cnt_reg, out_cnt_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                win_vld_reg, win_vld_next;
    logic                out_vld_reg, out_vld_next;
    logic [RW-1:0]       out_cells_reg;
    logic [XW-1:0]       out_idx_reg;
    logic                out_last_reg;

    // Combinational
    logic [DW-1:0]  gh_c, h_eff, gw_c, w_eff, wmax7;
    logic [CW-1:0]  wmax;
    logic [NC-1:0]  wr_mask;
    logic [DW-1:0]  wr_idx;
    logic           in_acc;
    logic           adv, issue, shift, out_load, last_load;
    logic [CTW-1:0] h_ext, rd_addr_c;
    logic [NC-1:0]  rd_data, cell_next;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg <= lgt_pkg::GRID_WIDTH_RST;
            gh_reg <= lgt_pkg::GRID_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                lgt_pkg::REG_GRID_WIDTH:  gw_reg <= cfg_wdata;
                lgt_pkg::REG_GRID_HEIGHT: gh_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Effective width and height, clamped to the supported range
    assign gh_c  = (gh_reg == '0) ? DW'(1) : gh_reg;
    assign h_eff = (gh_c > DW'(H_CAP)) ? DW'(H_CAP) : gh_c;
    assign gw_c  = (gw_reg == '0) ? DW'(1) : gw_reg;
    assign w_eff = (gw_c > DW'(NC)) ? DW'(NC) : gw_c;
    assign wmax7 = w_eff - DW'(1);
    assign wmax  = CW'(wmax7);

    // Columns beyond the width are stored as zero
    always_comb
    begin
        for (int j = 0; j < NC; j++)
        begin
            wr_mask[j] = (DW'(j) < w_eff);
        end
    end

    // Load side
    assign in_row.ready = (st_reg == lgt_pkg::ST_LOAD);
    assign in_acc       = in_row.valid && in_row.ready;
    assign wr_idx       = (loaded_reg >= h_eff) ? '0 : loaded_reg;

    // Emission pipeline: read -> cell window -> output register
    assign adv       = !out_vld_reg || out_row.ready;
    assign h_ext     = CTW'(h_reg);
    assign issue     = (st_reg == lgt_pkg::ST_EMIT) && adv && (rd_cnt_reg <= h_ext + CTW'(1));
    assign shift     = adv && rd_vld_reg;
    assign out_load  = adv && win_vld_reg;
    assign last_load = out_load && (out_cnt_reg == h_reg - DW'(1));

    // Read order: last row, then 0 .. last row, then row 0 again
    always_comb
    begin
        if (rd_cnt_reg == '0)
        begin
            rd_addr_c = h_ext - CTW'(1);
        end
        else if (rd_cnt_reg == h_ext + CTW'(1))
        begin
            rd_addr_c = '0;
        end
        else
        begin
            rd_addr_c = rd_cnt_reg - CTW'(1);
        end
    end

    lgt_ram #(
        .WIDTH (NC),
        .DEPTH (MAX_ROWS)
    ) u_row_store (
        .clk   (clk),
        .we    (in_acc),
        .waddr (ROW_AW'(wr_idx)),
        .wdata (in_row.data.cur_row_cells[NC-1:0] & wr_mask),
        .re    (issue),
        .raddr (ROW_AW'(rd_addr_c)),
        .rdata (rd_data)
    );

    lgt_cell_row #(
        .NC (NC)
    ) u_cells (
        .clk      (clk),
        .shift    (shift),
        .row_in   (rd_data),
        .wmax     (wmax),
        .next_row (cell_next)
    );

    // Next state and counters
    always_comb
    begin
        st_next      = st_reg;
        loaded_next  = loaded_reg;
        h_next       = h_reg;
        rd_cnt_next  = rd_cnt_reg;
        sh_cnt_next  = sh_cnt_reg;
        out_cnt_next = out_cnt_reg;
        rd_vld_next  = rd_vld_reg;
        win_vld_next = win_vld_reg;
        out_vld_next = out_vld_reg;

        unique case (st_reg)
            lgt_pkg::ST_LOAD:
            begin
                if (in_acc)
                begin
                    if (wr_idx + DW'(1) == h_eff)
                    begin
                        st_next     = lgt_pkg::ST_EMIT;
                        h_next      = h_eff;
                        loaded_next = '0;
                    end
                    else
                    begin
                        loaded_next = wr_idx + DW'(1);
                    end
                end
            end
            lgt_pkg::ST_EMIT:
            begin
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + CTW'(1);
                end
                if (adv)
                begin
                    rd_vld_next  = issue;
                    win_vld_next = rd_vld_reg && (sh_cnt_reg >= CTW'(2));
                end
                if (shift)
                begin
                    sh_cnt_next = sh_cnt_reg + CTW'(1);
                end
                if (out_load)
                begin
                    out_cnt_next = out_cnt_reg + DW'(1);
                end
                if (last_load)
                begin
                    st_next      = lgt_pkg::ST_LOAD;
                    rd_cnt_next  = '0;
                    sh_cnt_next  = '0;
                    out_cnt_next = '0;
                end
            end
            default:
            begin
                st_next = lgt_pkg::ST_LOAD;
            end
        endcase

        // Output slot
        if (out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_row.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg      <= lgt_pkg::ST_LOAD;
            loaded_reg  <= '0;
            h_reg       <= DW'(1);
            rd_cnt_reg  <= '0;
            sh_cnt_reg  <= '0;
            out_cnt_reg <= '0;
            rd_vld_reg  <= 1'b0;
            win_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            st_reg      <= st_next;
            loaded_reg  <= loaded_next;
            h_reg       <= h_next;
            rd_cnt_reg  <= rd_cnt_next;
            sh_cnt_reg  <= sh_cnt_next;
            out_cnt_reg <= out_cnt_next;
            rd_vld_reg  <= rd_vld_next;
            win_vld_reg <= win_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_cells_reg <= RW'(cell_next);
            out_idx_reg   <= XW'(out_cnt_reg);
            out_last_reg  <= (out_cnt_reg == h_reg - DW'(1));
        end
    end

    assign out_row.valid               = out_vld_reg;
    assign out_row.data.next_row_cells = out_cells_reg;
    assign out_row.data.out_row_index  = out_idx_reg;
    assign out_row.data.last_row       = out_last_reg;

    // Checks
    `LGT_ASSERT(a_no_overwrite, clk, rst_n, out_vld_reg && !out_row.ready, !out_load, "output row overwritten while stalled")
    `LGT_ASSERT(a_window_filled, clk, rst_n, win_vld_reg, sh_cnt_reg >= CTW'(3), "cell window used before three rows shifted in")
    `LGT_ASSERT(a_load_in_emit, clk, rst_n, out_load, st_reg == lgt_pkg::ST_EMIT, "output row produced outside emission")
    `LGT_ASSERT(a_read_bound, clk, rst_n, st_reg == lgt_pkg::ST_EMIT, rd_cnt_reg <= h_ext + CTW'(2), "store read count past height plus two")
endmodule
